// ----- rtl/bitmap_block_allocator_unit_macros.svh -----
// assertion macros used by the block allocator controller
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication on aclk, off during reset
`define BBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bba assertion failed");

// next-cycle implication on aclk, off during reset
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bba assertion failed");

// condition that must never hold
`define BBA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("bba assertion failed");

`endif

// ----- rtl/bba_pkg.sv -----
// shared types, constants and helpers of the bitmap block allocator
package bba_pkg;

    localparam int NUM_BLOCKS    = 1024;
    localparam int RESERVED_LAST = 67;
    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = NUM_BLOCKS / WORD_W;
    localparam int WADDR_W       = $clog2(NUM_WORDS);
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int BLOCK_W       = 10;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;

    localparam int FIRST_FREE = RESERVED_LAST + 1;
    localparam int FIRST_WORD = FIRST_FREE / WORD_W;
    localparam int FIRST_BIT  = FIRST_FREE % WORD_W;

    localparam logic [WADDR_W-1:0] FIRST_WADDR = WADDR_W'(FIRST_WORD);
    localparam logic [WADDR_W-1:0] LAST_WADDR  = WADDR_W'(NUM_WORDS - 1);
    localparam logic [WORD_W-1:0]  FIRST_MASK  = {WORD_W{1'b1}} << FIRST_BIT;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RESERVED  = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_OUT
    } bba_state_t;

    typedef enum logic [1:0] {
        WR_INIT,
        WR_CLEAR_BIT,
        WR_SET_BIT
    } bba_wr_sel_t;

    typedef struct packed {
        logic        capture;
        logic        rd_en;
        logic        wr_en;
        bba_wr_sel_t wr_sel;
        logic        addr_inc;
        logic        res_load;
        logic        out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              found;
        logic              last_word;
        logic              free_ok;
        logic              out_free;
    } bba_sts_t;

    // reset contents of one bitmap word: reserved blocks used, others free
    function automatic logic [WORD_W-1:0] init_word(input logic [WADDR_W-1:0] waddr);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int b = 0; b < WORD_W; b++) begin
            w[b] = ((int'(waddr) * WORD_W + b) > RESERVED_LAST);
        end
        return w;
    endfunction

endpackage

// ----- rtl/bba_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/bba_ctrl.sv -----
// controller state machine of the bitmap block allocator
`include "bitmap_block_allocator_unit_macros.svh"

module bba_ctrl import bba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  bba_sts_t sts,
    output bba_cmd_t cmd
);

    bba_state_t state_reg;
    bba_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.wr_sel   = WR_INIT;
        s_tready     = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_INIT;
                cmd.addr_inc = 1'b1;
                if (sts.last_word) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                case (sts.kind)
                    KIND_ALLOC: begin
                        if (sts.found) begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = WR_CLEAR_BIT;
                            cmd.res_load = 1'b1;
                            state_next   = S_OUT;
                        end else if (sts.last_word) begin
                            cmd.res_load = 1'b1;
                            state_next   = S_OUT;
                        end else begin
                            cmd.addr_inc = 1'b1;
                            state_next   = S_READ;
                        end
                    end
                    KIND_FREE: begin
                        cmd.wr_en    = sts.free_ok;
                        cmd.wr_sel   = WR_SET_BIT;
                        cmd.res_load = 1'b1;
                        state_next   = S_OUT;
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        state_next   = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BBA_ASSERT_NEVER(a_no_rd_wr_same_cycle, cmd.wr_en && cmd.rd_en)
    `BBA_ASSERT_NEXT(a_accept_then_read, s_tvalid && s_tready, state_reg == S_READ)
    `BBA_ASSERT_IMP(a_out_load_free, cmd.out_load, sts.out_free)
    `BBA_ASSERT_IMP(a_alloc_write_found,
        cmd.wr_en && (state_reg == S_EVAL) && (sts.kind == KIND_ALLOC), sts.found)

endmodule

// ----- rtl/bba_dp.sv -----
// datapath of the bitmap block allocator: request regs, bitmap ram, encoder, result regs
module bba_dp import bba_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [BLOCK_W-1:0]   s_block,
    input  bba_cmd_t             cmd,
    output bba_sts_t             sts,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [KIND_W-1:0]   kind_reg;
    logic [BLOCK_W-1:0]  block_reg;
    logic [WADDR_W-1:0]  waddr_reg;
    logic [WADDR_W-1:0]  waddr_next;
    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   wr_data;
    logic [WORD_W-1:0]   scan_word;
    logic                found;
    logic [BIT_W-1:0]    found_bit;
    logic [BIT_W-1:0]    blk_bit;
    logic                in_range;
    logic                reserved;

    logic [STATUS_W-1:0] res_status_reg;
    logic [BLOCK_W-1:0]  res_granted_reg;
    logic                res_free_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [BLOCK_W-1:0]  res_granted_next;
    logic                res_free_next;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign blk_bit  = block_reg[BIT_W-1:0];
    assign in_range = (32'(block_reg) < NUM_BLOCKS);
    assign reserved = (32'(block_reg) <= RESERVED_LAST);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_kind;
            block_reg <= s_block;
        end
    end

    always_comb begin
        waddr_next = waddr_reg;
        if (cmd.capture) begin
            if (s_kind == KIND_ALLOC) begin
                waddr_next = FIRST_WADDR;
            end else begin
                waddr_next = WADDR_W'(s_block >> BIT_W);
            end
        end else if (cmd.addr_inc) begin
            waddr_next = waddr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waddr_reg <= '0;
        end else begin
            waddr_reg <= waddr_next;
        end
    end

    always_comb begin
        scan_word = (waddr_reg == FIRST_WADDR) ? (rd_data & FIRST_MASK) : rd_data;
        found     = |scan_word;
        found_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (scan_word[b]) begin
                found_bit = BIT_W'(b);
            end
        end
    end

    always_comb begin
        case (cmd.wr_sel)
            WR_CLEAR_BIT: wr_data = rd_data & ~(WORD_W'(1) << found_bit);
            WR_SET_BIT:   wr_data = rd_data | (WORD_W'(1) << blk_bit);
            default:      wr_data = init_word(waddr_reg);
        endcase
    end

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (waddr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (waddr_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        res_status_next  = ST_DONE;
        res_granted_next = '0;
        res_free_next    = 1'b0;
        case (kind_reg)
            KIND_ALLOC: begin
                if (found) begin
                    res_granted_next = BLOCK_W'({waddr_reg, found_bit});
                end else begin
                    res_status_next = ST_NONE_FREE;
                end
            end
            KIND_FREE: begin
                if (in_range && reserved) begin
                    res_status_next = ST_RESERVED;
                end
            end
            KIND_CHECK: begin
                res_free_next = in_range & rd_data[blk_bit];
            end
            default: begin
                res_status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg  <= res_status_next;
            res_granted_reg <= res_granted_next;
            res_free_reg    <= res_free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({res_free_reg, res_granted_reg, res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign sts.kind      = kind_reg;
    assign sts.found     = found;
    assign sts.last_word = (waddr_reg == LAST_WADDR);
    assign sts.free_ok   = in_range & ~reserved;
    assign sts.out_free  = ~m_tvalid_reg | m_tready;

endmodule

// ----- rtl/bitmap_block_allocator_unit.sv -----
// top level of the bitmap block allocator
// Free-block bitmap, one bit per block, 1 = free, kept in a 32-bit wide ram.
// Requests enter on the s_ stream: s_tuser carries the kind (allocate, free,
// check) and s_tdata the block number. Each request gives exactly one result
// transaction on the m_ stream: status, granted block and free bit.
// After reset the controller writes the reset image into the bitmap, one word
// per cycle, across all NUM_BLOCKS/32 words (32 at the default size); s_tready
// stays low during that sweep.
// Free and check pass from acceptance to result through capture, ram read,
// evaluate and result load. Allocate reads and evaluates one bitmap word at a
// time, starting at the word that holds the first block above the reserved
// region, with a priority encoder picking the lowest free bit; in the worst
// case at the default size it scans 30 words. One request is in flight at a time.
// The result sits in an output register; a new request is accepted while it
// waits, and if m_tready stays low the next result is held in the datapath
// until the output register is taken.
module bitmap_block_allocator_unit import bba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] block
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [1:0] status, [11:2] granted_block, [12] is_free
);

    bba_cmd_t cmd;
    bba_sts_t sts;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_kind   (s_tuser),
        .s_block  (s_tdata[BLOCK_W-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the bitmap block allocator: predicted map, random and directed requests
import bba_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  granted;
    logic                is_free;
} alloc_result_t;

class block_map_scoreboard;
    bit [NUM_BLOCKS-1:0] free_map;
    alloc_result_t       expected_results[$];
    int free_count;
    int fail_count;
    int n_requests;
    int n_results;
    int n_granted;
    int n_none_free;
    int n_reserved;
    int n_checks;

    function new();
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            free_map[i] = (i > RESERVED_LAST);
        end
        free_count = NUM_BLOCKS - FIRST_FREE;
    endfunction

    task report(string msg);
        $display("mismatch at result %0d: %s", n_results, msg);
        fail_count++;
    endtask

    // update the map for one accepted request and queue the result it must give
    function void note_request(logic [KIND_W-1:0] kind, logic [BLOCK_W-1:0] blk);
        alloc_result_t r;
        bit found;
        int i;
        r = '0;
        r.status = ST_DONE;
        found = 1'b0;
        n_requests++;
        case (kind)
            KIND_ALLOC: begin
                for (i = FIRST_FREE; i < NUM_BLOCKS && !found; i++) begin
                    if (free_map[i]) begin
                        free_map[i] = 1'b0;
                        r.granted = BLOCK_W'(i);
                        found = 1'b1;
                    end
                end
                if (found) begin
                    free_count--;
                    n_granted++;
                end else begin
                    r.status = ST_NONE_FREE;
                    n_none_free++;
                end
            end
            KIND_FREE: begin
                if (int'(blk) < NUM_BLOCKS) begin
                    if (int'(blk) <= RESERVED_LAST) begin
                        r.status = ST_RESERVED;
                        n_reserved++;
                    end else if (!free_map[blk]) begin
                        free_map[blk] = 1'b1;
                        free_count++;
                    end
                end
            end
            KIND_CHECK: begin
                n_checks++;
                if (int'(blk) < NUM_BLOCKS) begin
                    r.is_free = free_map[blk];
                end
            end
            default: ;
        endcase
        expected_results.push_back(r);
    endfunction

    task check_result(logic [M_TDATA_W-1:0] tdata);
        alloc_result_t want;
        n_results++;
        if (expected_results.size() == 0) begin
            report($sformatf("result %h with no request outstanding", tdata));
            return;
        end
        want = expected_results.pop_front();
        if (tdata[1:0] !== want.status) begin
            report($sformatf("status %0d, expected %0d", tdata[1:0], want.status));
        end
        if (tdata[11:2] !== want.granted) begin
            report($sformatf("granted_block %0d, expected %0d", tdata[11:2], want.granted));
        end
        if (tdata[12] !== want.is_free) begin
            report($sformatf("is_free %b, expected %b", tdata[12], want.is_free));
        end
    endtask
endclass

module tb_top;
    localparam logic [KIND_W-1:0]  KIND_UNUSED     = 2'd3;
    localparam logic [BLOCK_W-1:0] RES_TOP         = BLOCK_W'(RESERVED_LAST);
    localparam logic [BLOCK_W-1:0] FREE_BASE       = BLOCK_W'(FIRST_FREE);
    localparam logic [BLOCK_W-1:0] TOP_BLOCK       = BLOCK_W'(NUM_BLOCKS - 1);
    localparam int                 CYCLE_LIMIT     = 1000000;
    localparam int                 DRAIN_CYCLES    = 80;
    localparam int                 HOLD_OFF_CYCLES = 400;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    block_map_scoreboard sb = new();
    int cycle_count      = 0;
    bit quiet            = 1'b0;
    bit hold_off_request = 1'b0;
    bit send_idle_on     = 1'b1;

    always #5 aclk = ~aclk;

    bitmap_block_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check every transaction, stall in bursts or one long hold-off
    initial begin : result_sink
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_cnt = HOLD_OFF_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (!quiet && (cycle_count / 200) % 3 != 0 && $urandom_range(0, 4) == 0) begin
                hold_cnt = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BLOCK_W-1:0] blk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'(blk);
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_request(kind, blk);
    endtask

    task automatic sender_gap(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [BLOCK_W-1:0] pick_block();
        case ($urandom_range(0, 9))
            0, 1: return BLOCK_W'($urandom_range(0, RESERVED_LAST));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return RES_TOP;
                    2: return FREE_BASE;
                    default: return TOP_BLOCK;
                endcase
            end
            3, 4, 5: return BLOCK_W'($urandom_range(FIRST_FREE, FIRST_FREE + 95));
            default: return BLOCK_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int alloc_pct);
        logic [KIND_W-1:0] kind;
        int roll;
        if ($urandom_range(0, 39) == 0) begin
            send_idle_on = !send_idle_on;
        end
        if (!quiet && send_idle_on && $urandom_range(0, 3) == 0) begin
            sender_gap($urandom_range(1, 10));
        end
        if ($urandom_range(0, 99) < alloc_pct) begin
            kind = KIND_ALLOC;
        end else begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                kind = KIND_UNUSED;
            end else if (roll < 10) begin
                kind = KIND_FREE;
            end else begin
                kind = KIND_CHECK;
            end
        end
        send_request(kind, kind == KIND_ALLOC ? BLOCK_W'($urandom) : pick_block());
    endtask

    initial begin : stimulus
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(KIND_CHECK, '0);
        send_request(KIND_CHECK, RES_TOP);
        send_request(KIND_CHECK, FREE_BASE);
        send_request(KIND_CHECK, TOP_BLOCK);
        send_request(KIND_CHECK, 10'h2AA);
        send_request(KIND_CHECK, 10'h155);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, TOP_BLOCK);
        send_request(KIND_CHECK, FREE_BASE);
        send_request(KIND_FREE, RES_TOP);
        send_request(KIND_FREE, '0);
        send_request(KIND_FREE, FREE_BASE);
        send_request(KIND_CHECK, FREE_BASE);
        send_request(KIND_ALLOC, 10'h2AA);
        send_request(KIND_FREE, TOP_BLOCK);
        send_request(KIND_UNUSED, TOP_BLOCK);
        send_request(KIND_UNUSED, '0);
        send_request(KIND_FREE, FREE_BASE + 1'b1);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_CHECK, FREE_BASE + 1'b1);
        drain_results();

        // mixed traffic, with one long stall on the result side
        for (i = 0; i < 200; i++) begin
            if (i == 60) begin
                hold_off_request = 1'b1;
            end
            send_random(40);
        end
        drain_results();

        // mostly allocations so the scan runs across many bitmap words
        for (i = 0; i < 300; i++) begin
            send_random(90);
        end

        // traffic with fewer allocations, without idling, to reopen the map
        quiet = 1'b1;
        for (i = 0; i < 130; i++) begin
            send_random(30);
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests: %0d blocks granted, %0d refused on a full map, %0d reserved frees",
                 sb.n_requests, sb.n_granted, sb.n_none_free, sb.n_reserved);
        $display("%0d checks; %0d blocks left free, one %0d-cycle result stall",
                 sb.n_checks, sb.free_count, HOLD_OFF_CYCLES);
        if (sb.fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
